### rtl/thbc_pkg.sv
// Package for the tap/hold button classifier: payload structs, phase codes,
// configuration register indexes and reset values. No dependencies.
package thbc_pkg;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_SHORT = 2'd1,
        PHASE_LONG  = 2'd2
    } phase_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HOLD_TIME    = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_HOLD = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN     = 2'd2;

    localparam logic [15:0] HOLD_TIME_RESET    = 16'd500;
    localparam logic [15:0] DEFAULT_HOLD_RESET = 16'd500;
    localparam logic [15:0] COOLDOWN_RESET     = 16'd200;

    typedef struct packed {
        logic        pin_level;
        logic [15:0] elapsed_ms;
    } poll_t;

    typedef struct packed {
        logic   tap_event;
        logic   hold_event;
        phase_t press_phase;
    } result_t;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] default_hold_ms;
        logic [15:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [16:0] held_time;
        logic [15:0] lockout_left;
    } press_state_t;

endpackage

### rtl/tap_hold_button_classifier.sv
// Top level of the tap/hold button classifier: poll register, state and result registers.
// Depends on thbc_pkg, thbc_cfg_regs and thbc_step.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------------
//   poll     | in        | poll_valid / poll_stall   | pin_level, elapsed_ms
//   result   | out       | result_valid/result_stall | tap_event, hold_event, press_phase
//   cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One poll is accepted every cycle while poll_stall is low; it waits in the poll register,
// and its result is computed as it moves on into the result register, where it is taken.
// The rate is set by the loop from the press state registers through
// the step logic and back, which updates as the poll moves into the result register.
// Reset clears the phase to idle and both timers to zero, and restores the hold,
// default hold and cooldown registers to 500, 500 and 200 ms.
// A stalled result holds its register; the poll register then holds too, and
// poll_stall is raised only while it is full and cannot move on.
module tap_hold_button_classifier
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               poll_valid,
    output logic               poll_stall,
    input  thbc_pkg::poll_t    poll,

    output logic               result_valid,
    input  logic               result_stall,
    output thbc_pkg::result_t  result,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    thbc_pkg::cfg_t         cfg;

    logic                   poll_valid_reg;
    thbc_pkg::poll_t        poll_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    thbc_pkg::result_t      result_reg;
    thbc_pkg::press_state_t state_reg;
    thbc_pkg::press_state_t state_next;
    thbc_pkg::result_t      step_result;

    logic poll_take;
    logic advance;

    // The user must write the configuration only while the block is idle; the block
    // does not enforce this. cfg_ready is constant, so every request is taken at once.
    assign cfg_ready = 1'b1;

    thbc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    thbc_step u_step
    (
        .poll   (poll_reg),
        .cfg    (cfg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    // The held poll moves into the result register whenever that register is
    // empty or its contents are taken in this cycle.
    assign advance           = poll_valid_reg & (~result_valid_reg | ~result_stall);
    assign poll_stall        = poll_valid_reg & ~advance;
    assign poll_take         = poll_valid & ~poll_stall;
    assign result_valid_next = advance | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg.phase        <= thbc_pkg::PHASE_IDLE;
            state_reg.held_time    <= 17'd0;
            state_reg.lockout_left <= 16'd0;
        end
        else
        begin
            poll_valid_reg   <= poll_take | poll_stall;
            result_valid_reg <= result_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (poll_take)
            poll_reg <= poll;
        if (advance)
            result_reg <= step_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/thbc_cfg_regs.sv
// Configuration register file for the tap/hold button classifier.
// Depends on thbc_pkg for register indexes, reset values and cfg_t.
module thbc_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    output thbc_pkg::cfg_t     cfg
);

    thbc_pkg::cfg_t cfg_reg;
    thbc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                thbc_pkg::CFG_HOLD_TIME:    cfg_next.hold_time_ms    = wr_data;
                thbc_pkg::CFG_DEFAULT_HOLD: cfg_next.default_hold_ms = wr_data;
                thbc_pkg::CFG_COOLDOWN:     cfg_next.cooldown_ms     = wr_data;
                default:                    cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms    <= thbc_pkg::HOLD_TIME_RESET;
            cfg_reg.default_hold_ms <= thbc_pkg::DEFAULT_HOLD_RESET;
            cfg_reg.cooldown_ms     <= thbc_pkg::COOLDOWN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/thbc_step.sv
// Combinational update of the press state for one poll, and its result.
// Depends on thbc_pkg for phase_t and the payload and state structs.
module thbc_step
(
    input  thbc_pkg::poll_t        poll,
    input  thbc_pkg::cfg_t         cfg,
    input  thbc_pkg::press_state_t cur,
    output thbc_pkg::press_state_t nxt,
    output thbc_pkg::result_t      result
);

    logic        pressed;
    logic [15:0] lock_dec;
    logic [15:0] hold;
    logic [16:0] held_sum;
    logic        reached;
    thbc_pkg::phase_t phase_next;

    assign pressed  = ~poll.pin_level;
    assign lock_dec = (cur.lockout_left > poll.elapsed_ms) ?
                      (cur.lockout_left - poll.elapsed_ms) : 16'd0;
    assign hold     = (cfg.hold_time_ms != 16'd0) ? cfg.hold_time_ms : cfg.default_hold_ms;
    // The held time stays below the hold time before the add, so 17 bits hold the sum.
    assign held_sum = cur.held_time + {1'b0, poll.elapsed_ms};
    assign reached  = (held_sum >= {1'b0, hold});

    // Next phase.
    always_comb
    begin
        phase_next = cur.phase;
        if (!pressed)
        begin
            phase_next = thbc_pkg::PHASE_IDLE;
        end
        else
        begin
            case (cur.phase)
                thbc_pkg::PHASE_IDLE:
                    if (lock_dec == 16'd0)
                        phase_next = thbc_pkg::PHASE_SHORT;
                thbc_pkg::PHASE_SHORT:
                    if (reached)
                        phase_next = thbc_pkg::PHASE_LONG;
                default:
                    phase_next = cur.phase;
            endcase
        end
    end

    // Timers and events.
    always_comb
    begin
        nxt.phase        = phase_next;
        nxt.held_time    = cur.held_time;
        nxt.lockout_left = lock_dec;
        result.tap_event  = 1'b0;
        result.hold_event = 1'b0;
        if (!pressed)
        begin
            nxt.held_time = 17'd0;
            if (cur.phase != thbc_pkg::PHASE_IDLE)
                nxt.lockout_left = cfg.cooldown_ms;
            if (cur.phase == thbc_pkg::PHASE_SHORT)
                result.tap_event = 1'b1;
        end
        else
        begin
            case (cur.phase)
                thbc_pkg::PHASE_IDLE:
                    if (lock_dec == 16'd0)
                        nxt.held_time = 17'd0;
                thbc_pkg::PHASE_SHORT:
                begin
                    nxt.held_time     = held_sum;
                    result.hold_event = reached;
                end
                default:
                    nxt.held_time = cur.held_time;
            endcase
        end
        result.press_phase = phase_next;
    end

endmodule

### rtl/thbc_checker.sv
// Port-level checks for the tap/hold button classifier, bound to its top level.
// Depends on thbc_pkg and tap_hold_button_classifier.
module thbc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input thbc_pkg::result_t result
);

    // A stalled result stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A tap and a hold cannot come from the same poll.
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.tap_event && result.hold_event))
        else $error("tap and hold in one result");

    // A tap is a release, so the phase after it is idle.
    a_tap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tap_event |-> result.press_phase == thbc_pkg::PHASE_IDLE)
        else $error("tap without return to idle");

    // A hold event moves the press into the long phase.
    a_hold_long: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hold_event |-> result.press_phase == thbc_pkg::PHASE_LONG)
        else $error("hold event outside long phase");

endmodule

bind tap_hold_button_classifier thbc_checker u_thbc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### bench/tap_hold_button_classifier_test.sv
// Self-checking testbench for the tap/hold button classifier.
// Depends on thbc_pkg and tap_hold_button_classifier; a scoreboard class predicts
// every result while plain tasks drive polls and register writes and an initial block drives result stalls.
module tap_hold_button_classifier_test;

    // Index 3 is not a register; a write to it must leave every setting unchanged.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int PHASE_COUNT     = 10;
    localparam int POLLS_PER_PHASE = 60;

    // Predicts the classifier result for each accepted request and keeps the
    // expected results in acceptance order until the block delivers them.
    class tap_hold_scoreboard;
        thbc_pkg::cfg_t         regs;
        thbc_pkg::press_state_t press;
        thbc_pkg::result_t      pending_results[$];
        int                     errors;
        int                     polls;
        int                     taps;
        int                     holds;

        function new();
            regs.hold_time_ms    = thbc_pkg::HOLD_TIME_RESET;
            regs.default_hold_ms = thbc_pkg::DEFAULT_HOLD_RESET;
            regs.cooldown_ms     = thbc_pkg::COOLDOWN_RESET;
            press.phase          = thbc_pkg::PHASE_IDLE;
            press.held_time      = '0;
            press.lockout_left   = '0;
            errors = 0;
            polls  = 0;
            taps   = 0;
            holds  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                thbc_pkg::CFG_HOLD_TIME:    regs.hold_time_ms    = val;
                thbc_pkg::CFG_DEFAULT_HOLD: regs.default_hold_ms = val;
                thbc_pkg::CFG_COOLDOWN:     regs.cooldown_ms     = val;
                default:                    ;
            endcase
        endfunction

        // Hold time actually in force: a zero hold register falls back to the default.
        function logic [15:0] hold_limit();
            return (regs.hold_time_ms != 16'd0) ? regs.hold_time_ms : regs.default_hold_ms;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_poll(thbc_pkg::poll_t p);
            logic [15:0]       limit;
            logic [15:0]       ms;
            thbc_pkg::result_t r;
            limit = hold_limit();
            ms    = p.elapsed_ms;
            r.tap_event  = 1'b0;
            r.hold_event = 1'b0;
            // The lockout runs down on every poll, before any reload below.
            press.lockout_left = (press.lockout_left > ms) ? press.lockout_left - ms : 16'd0;
            if (p.pin_level == 1'b0)
            begin
                if (press.phase == thbc_pkg::PHASE_IDLE)
                begin
                    // A press during the lockout is simply ignored.
                    if (press.lockout_left == 16'd0)
                    begin
                        press.phase     = thbc_pkg::PHASE_SHORT;
                        press.held_time = '0;
                    end
                end
                else if (press.phase == thbc_pkg::PHASE_SHORT)
                begin
                    press.held_time = press.held_time + {1'b0, ms};
                    if (press.held_time >= {1'b0, limit})
                    begin
                        press.phase  = thbc_pkg::PHASE_LONG;
                        r.hold_event = 1'b1;
                    end
                end
            end
            else
            begin
                if (press.phase == thbc_pkg::PHASE_SHORT)
                    r.tap_event = 1'b1;
                if (press.phase != thbc_pkg::PHASE_IDLE)
                    press.lockout_left = regs.cooldown_ms;
                press.phase     = thbc_pkg::PHASE_IDLE;
                press.held_time = '0;
            end
            r.press_phase = press.phase;
            polls = polls + 1;
            taps  = taps + int'(r.tap_event);
            holds = holds + int'(r.hold_event);
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
            $display("mismatch %s: got %0d expected %0d after %0d polls",
                     what, got_v, exp_v, polls);
            errors = errors + 1;
        endtask

        task check_result(thbc_pkg::result_t got);
            thbc_pkg::result_t exp_r;
            if (pending_results.size() == 0)
            begin
                report("result with nothing pending", 32'(got), 32'd0);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.tap_event !== exp_r.tap_event)
                report("tap_event", 32'(got.tap_event), 32'(exp_r.tap_event));
            if (got.hold_event !== exp_r.hold_event)
                report("hold_event", 32'(got.hold_event), 32'(exp_r.hold_event));
            if (got.press_phase !== exp_r.press_phase)
                report("press_phase", 32'(got.press_phase), 32'(exp_r.press_phase));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              poll_valid;
    logic              poll_stall;
    thbc_pkg::poll_t   poll;
    logic              result_valid;
    logic              result_stall;
    thbc_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;

    tap_hold_scoreboard model;

    // When set, neither side inserts gaps, so the block sees full-rate traffic.
    bit no_gaps;
    int settings_used;

    tap_hold_button_classifier dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_stall   (poll_stall),
        .poll         (poll),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 15));
    endfunction

    // Presents one request after a random gap and returns at the edge where it is
    // taken. The valid line stays high on return, so the caller either sends the
    // next request in the same time step or lowers valid through drain_results.
    task automatic send_poll(input logic pin, input logic [15:0] ms);
        thbc_pkg::poll_t p;
        int              gap;
        p.pin_level  = pin;
        p.elapsed_ms = ms;
        gap = draw_gap();
        if (gap > 0)
        begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll       <= p;
        do
            @(posedge clk);
        while (poll_stall);
        model.note_poll(p);
    endtask

    // Stops the request stream and waits until the block has delivered every
    // result still owed. Register writes are only made from this quiet state.
    task automatic drain_results();
        poll_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow each other without a gap;
    // the caller lowers it once the last write has been taken.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        model.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [15:0] hold, input logic [15:0] dflt,
                                input logic [15:0] cool);
        write_reg(thbc_pkg::CFG_HOLD_TIME, hold);
        write_reg(thbc_pkg::CFG_DEFAULT_HOLD, dflt);
        write_reg(thbc_pkg::CFG_COOLDOWN, cool);
        cfg_valid <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    // Elapsed times are mostly small against the hold and cooldown times so that
    // presses cross the hold threshold in several steps and hit it exactly now
    // and then; the rest are zero, the maximum or fully random.
    function automatic logic [15:0] draw_elapsed();
        int scale;
        scale = model.hold_limit() / 4 + model.regs.cooldown_ms / 4 + 1;
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'd0;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, scale));
        endcase
    endfunction

    // One random register setting: mostly small hold and cooldown times, with
    // the zero-hold fallback, both hold registers at zero and full-range values.
    task automatic program_random_regs();
        logic [15:0] hold;
        logic [15:0] dflt;
        logic [15:0] cool;
        case ($urandom_range(0, 4))
            0:
            begin
                hold = 16'($urandom_range(1, 60));
                dflt = 16'($urandom_range(1, 60));
                cool = 16'($urandom_range(0, 40));
            end
            1:
            begin
                hold = 16'd0;
                dflt = 16'($urandom_range(1, 60));
                cool = 16'($urandom_range(0, 40));
            end
            2:
            begin
                hold = 16'd0;
                dflt = 16'd0;
                cool = 16'($urandom_range(0, 20));
            end
            3:
            begin
                hold = 16'($urandom_range(0, 65535));
                dflt = 16'($urandom_range(0, 65535));
                cool = 16'($urandom_range(0, 65535));
            end
            default:
            begin
                hold = 16'($urandom_range(60, 400));
                dflt = 16'($urandom_range(1, 400));
                cool = 16'($urandom_range(0, 300));
            end
        endcase
        program_regs(hold, dflt, cool);
    endtask

    // Result side: before each result the receiver stalls for a random number of
    // cycles, then takes the next result that shows up and checks it.
    initial
    begin : result_side
        int stall_len;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall_len = draw_gap();
            if (stall_len > 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!result_valid);
            model.check_result(result);
        end
    end

    // Hard limit on the run. The slowest correct run has both gaps at their maximum
    // for every request and still ends inside the limit.
    initial
    begin
        #4000000;
        $display("FAIL tap_hold_button_classifier");
        $finish;
    end

    initial
    begin : stimulus
        int phase_no;
        int phase_start;
        int kind;
        int n_rel;
        int n_press;
        model         = new();
        no_gaps       = 1'b0;
        settings_used = 1;
        rst_n         = 1'b0;
        poll_valid    = 1'b0;
        poll          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = thbc_pkg::CFG_HOLD_TIME;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (hold 500, cooldown 200).
        send_poll(1'b1, 16'd0);         // release while idle does nothing
        send_poll(1'b0, 16'hFFFF);      // new press; its elapsed time is not counted
        send_poll(1'b0, 16'd499);       // one short of the hold time
        send_poll(1'b0, 16'd1);         // reaches the hold time exactly: hold event
        send_poll(1'b0, 16'hFFFF);      // further holding stays long and silent
        send_poll(1'b1, 16'd0);         // release from long: lockout reload, no tap
        send_poll(1'b0, 16'd100);       // press during the lockout is ignored
        send_poll(1'b0, 16'd99);        // still one millisecond of lockout left
        send_poll(1'b0, 16'd1);         // lockout just expired: press accepted
        send_poll(1'b1, 16'd0);         // release from short: tap
        send_poll(1'b1, 16'hFFFF);      // lockout runs out while released
        send_poll(1'b0, 16'd0);
        send_poll(1'b0, 16'hFFFF);      // widest step past the hold time
        send_poll(1'b1, 16'hFFFF);      // countdown happens before the reload
        send_poll(1'b0, 16'd200);
        send_poll(1'b1, 16'h5555);      // tap
        send_poll(1'b0, 16'hAAAA);
        send_poll(1'b1, 16'd0);
        drain_results();

        // Both hold registers zero: the first pressed poll after a new press
        // already reaches the hold time. A zero cooldown never blocks a press.
        program_regs(16'd0, 16'd0, 16'd0);
        send_poll(1'b0, 16'd5);
        send_poll(1'b0, 16'd0);
        send_poll(1'b1, 16'd0);
        send_poll(1'b0, 16'd0);
        drain_results();

        // Largest hold and cooldown; the write to the unused index must not
        // disturb any register.
        program_regs(16'hFFFF, 16'd1, 16'hFFFF);
        @(posedge clk);
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_poll(1'b0, 16'd0);
        send_poll(1'b0, 16'hFFFF);
        send_poll(1'b1, 16'd0);
        send_poll(1'b0, 16'hFFFE);
        send_poll(1'b0, 16'd1);
        send_poll(1'b1, 16'd0);
        drain_results();

        // Random part: several register settings, each followed by press
        // sequences with random timing, some noise and occasional full drains.
        for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            program_random_regs();
            no_gaps     = ($urandom_range(0, 3) == 0);
            phase_start = model.polls;
            while (model.polls - phase_start < POLLS_PER_PHASE)
            begin
                kind = int'($urandom_range(0, 19));
                if (kind < 15)
                begin
                    n_rel   = int'($urandom_range(1, 3));
                    n_press = int'($urandom_range(1, 10));
                    repeat (n_rel) send_poll(1'b1, draw_elapsed());
                    repeat (n_press) send_poll(1'b0, draw_elapsed());
                end
                else if (kind < 19)
                begin
                    repeat ($urandom_range(1, 6))
                        send_poll(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end
                else
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        // Nothing is owed any more; let the clock run on so that the pipeline can show
        // any stray result before the verdict.
        no_gaps = 1'b1;
        repeat (10) @(posedge clk);

        $display("Run covered %0d polls under %0d register settings.",
                 model.polls, settings_used);
        $display("Predicted %0d tap events and %0d hold events; %0d mismatches.",
                 model.taps, model.holds, model.errors);
        if (model.errors == 0)
            $display("PASS tap_hold_button_classifier");
        else
            $display("FAIL tap_hold_button_classifier");
        $finish;
    end

endmodule
